// File: rtl/core/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue.
// Holds the command, status and cell-operation codes plus the payload structs.
// No dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_LEAVE  = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  level;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        t_cell_op op;
        t_entry   ent;
    } t_cell_ctl;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] entry_id;
        logic [7:0]  entry_level;
        logic [31:0] entry_payload;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [15:0]      out_id;
        logic [7:0]       out_level;
        logic [31:0]      out_payload;
        logic [CNT_W-1:0] occupancy;
    } t_out_item;

endpackage

// File: rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted chain; holds an entry and shifts with neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  logic              i_below_lower,
    input  spq_pkg::t_entry   i_below_ent,
    input  spq_pkg::t_entry   i_above_ent,
    input  logic              i_seen,
    output spq_pkg::t_entry   o_ent,
    output logic              o_lower,
    output logic              o_seen,
    output logic              o_first
);
    import spq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   match;

    assign o_lower = i_valid && (r_ent.level < i_ctl.ent.level);
    assign match   = i_valid && (r_ent.id == i_ctl.ent.id);
    assign o_seen  = i_seen | match;
    assign o_first = match & ~i_seen;
    assign o_ent   = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            OP_INSERT: begin
                // keep lower entries, drop new one in at the boundary, shift the rest up
                if (!o_lower) begin
                    n_ent = i_below_lower ? i_ctl.ent : i_below_ent;
                end
            end
            OP_REMOVE: begin
                if (o_seen) begin
                    n_ent = i_above_ent;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

// File: rtl/core/sorted_priority_queue_with_rekey.sv
// sorted_priority_queue_with_rekey: top level of the sorted-list priority queue.
// Depends on spq_pkg and spq_cell (a chain of QUEUE_DEPTH cells).
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  command  | i_start, o_busy, i_cmd         | transfer when i_start && !o_busy
//  result   | o_done, o_result               | one-cycle strobe, no backpressure
//
// Enqueue and leave act on the cell chain at the transfer edge, dequeue only lowers the
// entry count; the result strobes in the next cycle, and a new command may follow at once.
// A successful update takes two passes through the chain (remove, then insert),
// so o_busy is high for one cycle and its result strobes after the reinsert pass.
// Reset (synchronous, active low) clears the entry count, phase flag and done strobe; slot
// contents are not cleared, since only slots below the count are ever used.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sorted_priority_queue_with_rekey (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  spq_pkg::t_in_item  i_cmd,
    output logic               o_done,
    output spq_pkg::t_out_item o_result
);
    import spq_pkg::*;

    // Entry count and the pending second pass of an update.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_upd, n_upd;
    t_entry           r_upd_ent, n_upd_ent;
    logic             r_done, n_done;
    t_out_item        r_res, n_res;

    t_cell_ctl        ctl;
    logic             accept;
    logic             full, empty, found;

    logic [QUEUE_DEPTH-1:0] valid;
    logic [QUEUE_DEPTH-1:0] lower;
    logic [QUEUE_DEPTH-1:0] seen;
    logic [QUEUE_DEPTH-1:0] first;
    t_entry                 cell_ent [QUEUE_DEPTH];
    t_entry                 top_ent, hit_ent;

    assign accept = i_start && !r_upd;
    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);
    assign found  = seen[QUEUE_DEPTH-1];

    // Drive the chain: second pass of an update, else the accepted command.
    always_comb begin
        ctl.op  = OP_HOLD;
        ctl.ent = '{id: i_cmd.entry_id, level: i_cmd.entry_level,
                    payload: i_cmd.entry_payload};
        if (r_upd) begin
            ctl.op  = OP_INSERT;
            ctl.ent = r_upd_ent;
        end else if (accept) begin
            case (i_cmd.cmd) inside
                CMD_ENQ:    ctl.op = full ? OP_HOLD : OP_INSERT;
                CMD_LEAVE,
                CMD_UPDATE: ctl.op = OP_REMOVE;
                default:    ctl.op = OP_HOLD;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic   below_lower;
            t_entry below_ent;
            t_entry above_ent;
            logic   seen_in;

            assign valid[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_low
                assign below_lower = 1'b1;
                assign below_ent   = '0;
                assign seen_in     = 1'b0;
            end else begin : g_mid
                assign below_lower = lower[g-1];
                assign below_ent   = cell_ent[g-1];
                assign seen_in     = seen[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_high
                assign above_ent = '0;
            end else begin : g_next
                assign above_ent = cell_ent[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_valid       (valid[g]),
                .i_below_lower (below_lower),
                .i_below_ent   (below_ent),
                .i_above_ent   (above_ent),
                .i_seen        (seen_in),
                .o_ent         (cell_ent[g]),
                .o_lower       (lower[g]),
                .o_seen        (seen[g]),
                .o_first       (first[g])
            );
        end
    endgenerate

    // Pick the highest occupied slot and the first id match; both one-hot.
    always_comb begin
        top_ent = '0;
        hit_ent = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (valid[k] && (k == QUEUE_DEPTH - 1 || !valid[(k + 1) % QUEUE_DEPTH])) begin
                top_ent = top_ent | cell_ent[k];
            end
            if (first[k]) begin
                hit_ent = hit_ent | cell_ent[k];
            end
        end
    end

    // Next count, result and update phase.
    always_comb begin
        n_count   = r_count;
        n_upd     = 1'b0;
        n_upd_ent = r_upd_ent;
        n_done    = 1'b0;
        n_res     = '0;
        if (r_upd) begin
            // second pass: entry goes back in with its new level
            n_count = r_count + CNT_W'(1);
            n_done  = 1'b1;
        end else if (accept) begin
            n_done = 1'b1;
            case (i_cmd.cmd)
                CMD_ENQ: begin
                    if (full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_DEQ: begin
                    if (empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_count           = r_count - CNT_W'(1);
                        n_res.out_id      = top_ent.id;
                        n_res.out_level   = top_ent.level;
                        n_res.out_payload = top_ent.payload;
                    end
                end
                CMD_LEAVE: begin
                    if (empty) begin
                        n_res.status = ST_EMPTY;
                    end else if (!found) begin
                        n_res.status = ST_NOTFOUND;
                    end else begin
                        n_count           = r_count - CNT_W'(1);
                        n_res.out_id      = hit_ent.id;
                        n_res.out_level   = hit_ent.level;
                        n_res.out_payload = hit_ent.payload;
                    end
                end
                default: begin
                    if (empty) begin
                        n_res.status = ST_EMPTY;
                    end else if (!found) begin
                        n_res.status = ST_NOTFOUND;
                    end else begin
                        // hold the result until the reinsert pass
                        n_count   = r_count - CNT_W'(1);
                        n_upd     = 1'b1;
                        n_done    = 1'b0;
                        n_upd_ent = '{id: i_cmd.entry_id, level: i_cmd.entry_level,
                                      payload: hit_ent.payload};
                    end
                end
            endcase
        end
        n_res.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_upd   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_upd   <= n_upd;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd_ent <= n_upd_ent;
        r_res     <= n_res;
    end

    assign o_busy   = r_upd;
    assign o_done   = r_done;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_upd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd |=> (!r_upd && r_done))
        else $error("update reinsert pass did not finish in one cycle");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.status == ST_FULL) |-> (r_res.occupancy == CNT_W'(QUEUE_DEPTH)))
        else $error("full status reported with queue not full");

    a_upd_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_upd) && r_done |-> (r_res.status == ST_OK && r_res.out_id == '0))
        else $error("update result carries output entry");

endmodule

// File: dv/tb_sorted_priority_queue_with_rekey.sv
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_with_rekey: directed, fill-to-full and random traffic.
// Keeps its own sorted-list copy of the queue and checks every result strobe against it.
// Depends on spq_pkg and the RTL of the block.
module tb_sorted_priority_queue_with_rekey;
    import spq_pkg::*;

    localparam int STALL_LIMIT = 1000;  // cycles with no transfer before giving up
    localparam int MAX_REPORTS = 50;    // keep the log short if the block is badly broken

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_cmd;
    logic       o_done;
    t_out_item  o_result;

    sorted_priority_queue_with_rekey dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the queue: slot 0 is the low end, levels ascending.
    logic [7:0]  level_of   [QUEUE_DEPTH];
    logic [15:0] id_of      [QUEUE_DEPTH];
    logic [31:0] payload_of [QUEUE_DEPTH];
    int          held = 0;

    t_out_item   pending_results [$];   // one entry per accepted command, oldest first
    int          n_fail      = 0;
    int          gap_pct     = 0;       // chance of idling the command side after a transfer
    bit          start_armed = 1'b0;    // mirrors i_start without waiting for the NBA
    int          stall_cycles = 0;

    // Insert in front of the first entry whose level is not lower, so equal
    // levels keep arrival order with the oldest nearest the high end.
    function automatic void shadow_insert(logic [15:0] id, logic [7:0] lv, logic [31:0] pay);
        int pos;
        pos = 0;
        while (pos < held && level_of[pos] < lv) pos++;
        for (int k = held; k > pos; k--) begin
            level_of[k]   = level_of[k - 1];
            id_of[k]      = id_of[k - 1];
            payload_of[k] = payload_of[k - 1];
        end
        level_of[pos]   = lv;
        id_of[pos]      = id;
        payload_of[pos] = pay;
        held++;
    endfunction

    // Remove one slot and close the gap above it.
    function automatic void shadow_remove(int pos);
        for (int k = pos; k + 1 < held; k++) begin
            level_of[k]   = level_of[k + 1];
            id_of[k]      = id_of[k + 1];
            payload_of[k] = payload_of[k + 1];
        end
        held--;
    endfunction

    // Apply one command to the shadow queue and return the result it must produce.
    function automatic t_out_item apply_cmd(t_in_item it);
        t_out_item   res;
        int          pos;
        logic [31:0] kept;
        res = '0;
        res.status = ST_OK;
        if (it.cmd == CMD_ENQ) begin
            if (held >= QUEUE_DEPTH) res.status = ST_FULL;
            else shadow_insert(it.entry_id, it.entry_level, it.entry_payload);
        end else if (held == 0) begin
            res.status = ST_EMPTY;
        end else if (it.cmd == CMD_DEQ) begin
            res.out_id      = id_of[held - 1];
            res.out_level   = level_of[held - 1];
            res.out_payload = payload_of[held - 1];
            held--;
        end else begin
            // leave and update both act on the first id match from the low end
            pos = 0;
            while (pos < held && id_of[pos] != it.entry_id) pos++;
            if (pos >= held) begin
                res.status = ST_NOTFOUND;
            end else if (it.cmd == CMD_LEAVE) begin
                res.out_id      = id_of[pos];
                res.out_level   = level_of[pos];
                res.out_payload = payload_of[pos];
                shadow_remove(pos);
            end else begin
                kept = payload_of[pos];
                shadow_remove(pos);
                shadow_insert(it.entry_id, it.entry_level, kept);
            end
        end
        res.occupancy = CNT_W'(held);
        return res;
    endfunction

    function automatic t_in_item make_item(t_cmd c, logic [15:0] id, logic [7:0] lv,
                                           logic [31:0] pay);
        t_in_item it;
        it.cmd           = c;
        it.entry_id      = id;
        it.entry_level   = lv;
        it.entry_payload = pay;
        return it;
    endfunction

    // Present one command and hold it until the transfer edge; predict its
    // result at that edge. Called at a rising edge. Start stays high into the
    // next command unless a gap is drawn.
    task automatic send_cmd(input t_in_item it);
        i_start     <= 1'b1;
        i_cmd       <= it;
        start_armed  = 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(apply_cmd(it));
        if ($urandom_range(99) < gap_pct) begin
            i_start     <= 1'b0;
            start_armed  = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Idle the command side and wait for every outstanding result.
    task automatic wait_for_results();
        if (start_armed) begin
            i_start     <= 1'b0;
            start_armed  = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Every strobe is a transfer: compare it with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $error("unexpected result: status %0d, id 0x%0h", o_result.status,
                           o_result.out_id);
            end else begin
                want = pending_results.pop_front();
                check_field("status",      32'(want.status),    32'(o_result.status));
                check_field("out_id",      32'(want.out_id),    32'(o_result.out_id));
                check_field("out_level",   32'(want.out_level), 32'(o_result.out_level));
                check_field("out_payload", want.out_payload,    o_result.out_payload);
                check_field("occupancy",   32'(want.occupancy), 32'(o_result.occupancy));
            end
        end
    end

    // Count cycles with neither a command nor a result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $error("no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT,
               pending_results.size());
        $display("tb_sorted_priority_queue_with_rekey: FAIL");
        $finish;
    end

    // Empty-queue errors, field extremes, FIFO among equal levels, duplicate
    // ids, misses and re-keys in both directions; ends with the queue empty.
    task automatic test_directed_cases();
        gap_pct = 0;
        send_cmd(make_item(CMD_DEQ,    16'h0000, 8'h00, 32'h0));
        send_cmd(make_item(CMD_LEAVE,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(make_item(CMD_UPDATE, 16'h0000, 8'h10, 32'h0));
        send_cmd(make_item(CMD_ENQ,    16'h0000, 8'h00, 32'h0000_0000));
        send_cmd(make_item(CMD_ENQ,    16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(make_item(CMD_ENQ,    16'h0001, 8'h80, 32'hA5A5_A5A5));
        send_cmd(make_item(CMD_ENQ,    16'h0002, 8'h80, 32'h5A5A_5A5A));
        // second entry with id 1, lower level, so it sits nearer the low end
        send_cmd(make_item(CMD_ENQ,    16'h0001, 8'h10, 32'h1111_2222));
        send_cmd(make_item(CMD_LEAVE,  16'h1234, 8'h00, 32'h0));
        send_cmd(make_item(CMD_UPDATE, 16'h1234, 8'h40, 32'h0));
        send_cmd(make_item(CMD_LEAVE,  16'h0001, 8'h00, 32'h0));
        send_cmd(make_item(CMD_UPDATE, 16'h0000, 8'hFF, 32'hDEAD_BEEF));
        send_cmd(make_item(CMD_UPDATE, 16'hFFFF, 8'h00, 32'h0));
        send_cmd(make_item(CMD_UPDATE, 16'h0002, 8'h80, 32'h0));
        repeat (5) send_cmd(make_item(CMD_DEQ, 16'h0000, 8'h00, 32'h0));
        send_cmd(make_item(CMD_LEAVE,  16'h0000, 8'h00, 32'h0));
        wait_for_results();
    endtask

    // Fill to capacity, hit the full rejection, re-key while full, then empty out.
    task automatic test_fill_to_capacity();
        gap_pct = 38;
        while (held < QUEUE_DEPTH)
            send_cmd(make_item(CMD_ENQ, 16'($urandom), 8'($urandom), $urandom));
        repeat (2) send_cmd(make_item(CMD_ENQ, 16'($urandom), 8'($urandom), $urandom));
        send_cmd(make_item(CMD_UPDATE, id_of[$urandom_range(QUEUE_DEPTH - 1)],
                           8'($urandom), $urandom));
        while (held > 0) send_cmd(make_item(CMD_DEQ, 16'($urandom), 8'($urandom), $urandom));
        send_cmd(make_item(CMD_DEQ, 16'h0000, 8'h00, 32'h0));
        wait_for_results();
    endtask

    // Mostly meaningful traffic: a drifting fill goal sweeps occupancy from
    // empty to full, removals mostly name ids that are held, and a small id
    // and level pool forces duplicates and ties. A few items are pure noise.
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        t_in_item it;
        int       fill_goal;
        int       enq_pct;
        gap_pct   = idle_pct;
        fill_goal = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) fill_goal = $urandom_range(QUEUE_DEPTH);
            it.entry_id      = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom);
            it.entry_level   = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            it.entry_payload = $urandom;
            if ($urandom_range(99) < 6) begin
                it.cmd = t_cmd'(2'($urandom_range(3)));
            end else begin
                enq_pct = (held < fill_goal) ? 75 : 20;
                if ($urandom_range(99) < enq_pct) begin
                    it.cmd = CMD_ENQ;
                end else begin
                    case ($urandom_range(2))
                        0: it.cmd = CMD_DEQ;
                        1: it.cmd = CMD_LEAVE;
                        default: it.cmd = CMD_UPDATE;
                    endcase
                    if (held > 0 && $urandom_range(99) < 80)
                        it.entry_id = id_of[$urandom_range(held - 1)];
                end
            end
            send_cmd(it);
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cmd   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic(260, 0);
        test_random_traffic(260, 63);
        test_random_traffic(260, 38);

        // let any stray strobe show up before the verdict
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("tb_sorted_priority_queue_with_rekey: PASS");
        else
            $display("tb_sorted_priority_queue_with_rekey: FAIL");
        $finish;
    end

endmodule
